>>> src/mts_pkg.sv
// Shared types and codes for the max-tracking stack.
package mts_pkg;

    localparam int DATA_W = 32;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;
    typedef logic signed [DATA_W-1:0] word_t;

    localparam cmd_t CMD_PUSH = 2'd0;
    localparam cmd_t CMD_POP  = 2'd1;
    localparam cmd_t CMD_TOP  = 2'd2;
    localparam cmd_t CMD_MAX  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_OVER  = 2'd2;

    // Shift control shared by every cell of one chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

>>> src/mts_in_if.sv
// Command channel: valid/ready handshake carrying cmd and push_value.
interface mts_in_if
    import mts_pkg::*;
();
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    word_t push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

>>> src/mts_out_if.sv
// Result channel: valid/ready handshake carrying status and data.
interface mts_out_if
    import mts_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    word_t   data;

    modport source (output valid, output status, output data, input ready);
    modport sink   (input valid, input status, input data, output ready);
endinterface

>>> src/mts_cell.sv
// One stack cell: loads from the cell above on push, from the cell below on pop.
module mts_cell
    import mts_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      upper,
    input  word_t      lower,
    output word_t      value
);

    word_t value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            value_reg <= upper;
        end
        else if (ctrl.pop)
        begin
            value_reg <= lower;
        end
    end

    assign value = value_reg;

endmodule

>>> src/mts_chain.sv
// Row of stack cells; cell 0 always holds the top of the stack.
module mts_chain
    import mts_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      push_value,
    output word_t      top
);

    word_t vals [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t upper;
        word_t lower;

        if (i == 0)
        begin : g_head
            assign upper = push_value;
        end
        else
        begin : g_body
            assign upper = vals[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign lower = '0;
        end
        else
        begin : g_inner
            assign lower = vals[i+1];
        end

        mts_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .upper (upper),
            .lower (lower),
            .value (vals[i])
        );
    end

    assign top = vals[0];

endmodule

>>> src/max_tracking_stack.sv
// Top level of the max-tracking stack: value and maxima chains plus control.
//
// Usage: commands arrive on in_ch (cmd, push_value), one result per command
// leaves on out_ch (status, data). Commands are push, pop, read top and read
// maximum; reads return data with status ok, or status empty and data zero.
// A pop on an empty stack gives status empty, a push onto a full stack is
// dropped with status overflow.
// Both stacks are shifting rows of STACK_DEPTH cells whose first cell is the
// top, so every command needs only the two head cells. The result is
// registered; out_ch.valid rises in the cycle after acceptance. With
// out_ch.ready high, throughput is one command per cycle. The result register
// decouples the two sides: a new command is taken while a result waits, as
// long as out_ch.ready is high or the result register is free. When the
// receiver stalls, the result holds and in_ch.ready falls until it is taken.
// Reset clears both counts and the result valid flag; cell contents are
// undefined until pushed and are never reported.
module max_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    mts_in_if.sink    in_ch,
    mts_out_if.source out_ch
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT_W-1:0] mcnt_reg, mcnt_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    word_t            data_reg, data_next;

    cell_ctrl_t vctrl, mctrl;
    word_t      val_top, max_top;
    logic       accept;
    logic       v_empty, v_full, m_empty, m_full;

    mts_chain #(.DEPTH(STACK_DEPTH)) u_values (
        .clk        (clk),
        .ctrl       (vctrl),
        .push_value (in_ch.push_value),
        .top        (val_top)
    );

    mts_chain #(.DEPTH(STACK_DEPTH)) u_maxima (
        .clk        (clk),
        .ctrl       (mctrl),
        .push_value (in_ch.push_value),
        .top        (max_top)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign v_empty = (vcnt_reg == '0);
    assign v_full  = (vcnt_reg == FULL_CNT);
    assign m_empty = (mcnt_reg == '0);
    assign m_full  = (mcnt_reg == FULL_CNT);

    always_comb
    begin
        vctrl       = '0;
        mctrl       = '0;
        status_next = ST_OK;
        data_next   = '0;

        unique case (in_ch.cmd)
            CMD_PUSH:
            begin
                if (v_full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    vctrl.push = 1'b1;
                    // a value equal to the maximum goes on again for duplicates
                    if (!m_full && (m_empty || in_ch.push_value >= max_top))
                    begin
                        mctrl.push = 1'b1;
                    end
                end
            end
            CMD_POP:
            begin
                if (v_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    vctrl.pop = 1'b1;
                    if (!m_empty && max_top == val_top)
                    begin
                        mctrl.pop = 1'b1;
                    end
                end
            end
            CMD_TOP:
            begin
                if (v_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_next = val_top;
                end
            end
            CMD_MAX:
            begin
                if (m_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_next = max_top;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        // drop all updates unless a transaction is taken
        if (!accept)
        begin
            vctrl = '0;
            mctrl = '0;
        end
    end

    always_comb
    begin
        vcnt_next = vcnt_reg;
        mcnt_next = mcnt_reg;
        if (vctrl.push)
        begin
            vcnt_next = vcnt_reg + 1'b1;
        end
        else if (vctrl.pop)
        begin
            vcnt_next = vcnt_reg - 1'b1;
        end
        if (mctrl.push)
        begin
            mcnt_next = mcnt_reg + 1'b1;
        end
        else if (mctrl.pop)
        begin
            mcnt_next = mcnt_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg      <= vcnt_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.data   = data_reg;

endmodule
